// File: rtl/cfar_2d_detector_core_macros.svh
// ---------------------------------------------------------------------------
// cfar_2d_detector_core_macros.svh
// Assertion macros shared by the 2-D CFAR detector RTL.
// ---------------------------------------------------------------------------
`ifndef CFAR_2D_DETECTOR_CORE_MACROS_SVH
`define CFAR_2D_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define CFAR2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define CFAR2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cfar2d_pkg.sv
// ---------------------------------------------------------------------------
// cfar2d_pkg
// Shared constants, codes and controller/datapath types of the 2-D CFAR.
// ---------------------------------------------------------------------------
`default_nettype none

package cfar2d_pkg;

  // Default sizing
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int MAX_OUTER_DEF   = 8;
  localparam int POWER_BITS_DEF  = 32;

  // Register file layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_ROWS_W = 11;
  localparam int NUM_COLS_W = 9;
  localparam int RADIUS_W   = 3;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;

  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 11'd1024;
  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 9'd256;
  localparam logic [RADIUS_W-1:0]   TRAIN_RST    = 3'd4;
  localparam logic [RADIUS_W-1:0]   GUARD_RST    = 3'd1;
  localparam logic [SCALE_W-1:0]    SCALE_RST    = 16'd1536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS    = 3'd0,
    CFG_NUM_COLUMNS = 3'd1,
    CFG_TRAINING    = 3'd2,
    CFG_GUARD       = 3'd3,
    CFG_SCALE       = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_CHK,
    ST_BORROW,
    ST_TEST,
    ST_WIN,
    ST_WDRAIN,
    ST_MUL,
    ST_MDRAIN,
    ST_CMP,
    ST_OUT
  } state_t;

  // Partial products of the threshold compare
  typedef enum logic [1:0] {
    PASS_CEN_LO = 2'd0,
    PASS_CEN_HI = 2'd1,
    PASS_SUM_LO = 2'd2,
    PASS_SUM_HI = 2'd3
  } mul_pass_t;

  typedef struct packed {
    logic take;
    logic pos;
    logic borrow;
    logic win_init;
    logic win_step;
    logic mul_step;
    logic cmp;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic early;
    logic cc_neg;
    logic interior;
    logic win_last;
    logic mul_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/cfar2d_in_if.sv
// ---------------------------------------------------------------------------
// cfar2d_in_if
// Input channel: one power cell per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfar2d_in_if #(
  parameter int POWER_BITS = cfar2d_pkg::POWER_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  start_of_frame;
  logic [POWER_BITS-1:0] power_value;

  modport source (output valid, output start_of_frame, output power_value, input ready);
  modport sink   (input valid, input start_of_frame, input power_value, output ready);
endinterface

`default_nettype wire

// File: rtl/cfar2d_out_if.sv
// ---------------------------------------------------------------------------
// cfar2d_out_if
// Result channel: one verdict per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfar2d_out_if #(
  parameter int ROW_BITS = $clog2(cfar2d_pkg::MAX_ROWS_DEF),
  parameter int COL_BITS = $clog2(cfar2d_pkg::MAX_COLUMNS_DEF)
);
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] cell_row;
  logic [COL_BITS-1:0] cell_column;
  logic                detected;

  modport source (output valid, output cell_row, output cell_column, output detected,
                  input ready);
  modport sink   (input valid, input cell_row, input cell_column, input detected,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/cfar2d_ram.sv
// ---------------------------------------------------------------------------
// cfar2d_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cfar2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4352
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfar2d_cfg.sv
// ---------------------------------------------------------------------------
// cfar2d_cfg
// Register file and clamping of map size and radii.
// ---------------------------------------------------------------------------
`default_nettype none

module cfar2d_cfg #(
  parameter int MAX_COLUMNS = cfar2d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cfar2d_pkg::MAX_ROWS_DEF,
  parameter int MAX_OUTER   = cfar2d_pkg::MAX_OUTER_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cfar2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfar2d_pkg::CFG_DATA_W-1:0] cfg_data,
  output      logic [$clog2(MAX_COLUMNS+1)-1:0]  cols,
  output      logic [$clog2(MAX_ROWS+1)-1:0]     rows,
  output      logic [$clog2(MAX_OUTER+1)-1:0]    outer,
  output      logic [$clog2(MAX_OUTER+1)-1:0]    guard,
  output      logic [cfar2d_pkg::SCALE_W-1:0]    scale
);

  localparam int COLS_W = $clog2(MAX_COLUMNS+1);
  localparam int ROWS_W = $clog2(MAX_ROWS+1);
  localparam int OW     = $clog2(MAX_OUTER+1);

  logic [cfar2d_pkg::NUM_ROWS_W-1:0] rows_raw_r;
  logic [cfar2d_pkg::NUM_COLS_W-1:0] cols_raw_r;
  logic [cfar2d_pkg::RADIUS_W-1:0]   train_raw_r;
  logic [cfar2d_pkg::RADIUS_W-1:0]   guard_raw_r;
  logic [cfar2d_pkg::SCALE_W-1:0]    scale_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_raw_r  <= cfar2d_pkg::NUM_ROWS_RST;
      cols_raw_r  <= cfar2d_pkg::NUM_COLS_RST;
      train_raw_r <= cfar2d_pkg::TRAIN_RST;
      guard_raw_r <= cfar2d_pkg::GUARD_RST;
      scale_r     <= cfar2d_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfar2d_pkg::CFG_NUM_ROWS:    rows_raw_r  <= cfg_data[cfar2d_pkg::NUM_ROWS_W-1:0];
        cfar2d_pkg::CFG_NUM_COLUMNS: cols_raw_r  <= cfg_data[cfar2d_pkg::NUM_COLS_W-1:0];
        cfar2d_pkg::CFG_TRAINING:    train_raw_r <= cfg_data[cfar2d_pkg::RADIUS_W-1:0];
        cfar2d_pkg::CFG_GUARD:       guard_raw_r <= cfg_data[cfar2d_pkg::RADIUS_W-1:0];
        cfar2d_pkg::CFG_SCALE:       scale_r     <= cfg_data[cfar2d_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to 1..max, clamp training to MAX_OUTER, then cut guard to the rest
  always_comb begin
    int c_i;
    int r_i;
    int t_i;
    int g_i;
    c_i = int'(cols_raw_r);
    r_i = int'(rows_raw_r);
    t_i = int'(train_raw_r);
    g_i = int'(guard_raw_r);
    if (c_i < 1) c_i = 1;
    if (c_i > MAX_COLUMNS) c_i = MAX_COLUMNS;
    if (r_i < 1) r_i = 1;
    if (r_i > MAX_ROWS) r_i = MAX_ROWS;
    if (t_i > MAX_OUTER) t_i = MAX_OUTER;
    if (g_i > MAX_OUTER - t_i) g_i = MAX_OUTER - t_i;
    cols  = COLS_W'(c_i);
    rows  = ROWS_W'(r_i);
    outer = OW'(t_i + g_i);
    guard = OW'(g_i);
  end

  assign scale = scale_r;

endmodule

`default_nettype wire

// File: rtl/cfar2d_ctrl.sv
// ---------------------------------------------------------------------------
// cfar2d_ctrl
// Sequencer for one cell: locate, border test, window sweep, compare, emit.
// ---------------------------------------------------------------------------
`default_nettype none

module cfar2d_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire cfar2d_pkg::dp_status_t status,
  output      cfar2d_pkg::ctrl_cmd_t  cmd
);

  cfar2d_pkg::state_t state_r;
  cfar2d_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfar2d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      cfar2d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = cfar2d_pkg::ST_POS;
        end
      end
      cfar2d_pkg::ST_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = cfar2d_pkg::ST_CHK;
      end
      cfar2d_pkg::ST_CHK: begin
        // drop cells that have no verdict yet
        state_nxt = status.early ? cfar2d_pkg::ST_IDLE : cfar2d_pkg::ST_BORROW;
      end
      cfar2d_pkg::ST_BORROW: begin
        if (status.cc_neg) begin
          cmd.borrow = 1'b1;
        end else begin
          state_nxt = cfar2d_pkg::ST_TEST;
        end
      end
      cfar2d_pkg::ST_TEST: begin
        cmd.win_init = 1'b1;
        state_nxt    = status.interior ? cfar2d_pkg::ST_WIN : cfar2d_pkg::ST_OUT;
      end
      cfar2d_pkg::ST_WIN: begin
        cmd.win_step = 1'b1;
        if (status.win_last) begin
          state_nxt = cfar2d_pkg::ST_WDRAIN;
        end
      end
      cfar2d_pkg::ST_WDRAIN: begin
        state_nxt = cfar2d_pkg::ST_MUL;
      end
      cfar2d_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) begin
          state_nxt = cfar2d_pkg::ST_MDRAIN;
        end
      end
      cfar2d_pkg::ST_MDRAIN: begin
        state_nxt = cfar2d_pkg::ST_CMP;
      end
      cfar2d_pkg::ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = cfar2d_pkg::ST_OUT;
      end
      cfar2d_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cfar2d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfar2d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/cfar2d_dp.sv
// ---------------------------------------------------------------------------
// cfar2d_dp
// Datapath: raster position, line store, window sum, threshold compare and
// the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cfar2d_dp #(
  parameter int MAX_COLUMNS = cfar2d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cfar2d_pkg::MAX_ROWS_DEF,
  parameter int MAX_OUTER   = cfar2d_pkg::MAX_OUTER_DEF,
  parameter int POWER_BITS  = cfar2d_pkg::POWER_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cfar2d_pkg::ctrl_cmd_t            cmd,
  output      cfar2d_pkg::dp_status_t           status,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0] cols,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]    rows,
  input  wire logic [$clog2(MAX_OUTER+1)-1:0]   outer,
  input  wire logic [$clog2(MAX_OUTER+1)-1:0]   guard,
  input  wire logic [cfar2d_pkg::SCALE_W-1:0]   scale,
  input  wire logic                             in_sof,
  input  wire logic [POWER_BITS-1:0]            in_power,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [$clog2(MAX_ROWS)-1:0]      out_row,
  output      logic [$clog2(MAX_COLUMNS)-1:0]   out_col,
  output      logic                             out_det
);

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COLS_W  = $clog2(MAX_COLUMNS+1);
  localparam int ROWS_W  = $clog2(MAX_ROWS+1);
  localparam int OW      = $clog2(MAX_OUTER+1);
  localparam int RING    = 2*MAX_OUTER + 1;
  localparam int RING_W  = $clog2(RING);
  localparam int DEPTH   = RING*MAX_COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CW2     = COLS_W + 1;
  localparam int RW2     = ROWS_W + 1;
  localparam int P_W     = ((ROW_W > OW) ? ROW_W : OW) + COLS_W + 1;
  localparam int CR_W    = ((ROW_W > OW) ? ROW_W : OW) + 3;
  localparam int CC_W    = ((COL_W > OW) ? COL_W : OW) + 3;
  localparam int CELLS_W = $clog2(RING*RING);
  localparam int SUM_W   = POWER_BITS + CELLS_W;
  localparam int K_W     = CELLS_W + cfar2d_pkg::SCALE_FRAC;
  localparam int CL      = (POWER_BITS + 1) / 2;
  localparam int SL      = (SUM_W + 1) / 2;
  localparam int A_W     = SL;
  localparam int B_W     = (K_W > cfar2d_pkg::SCALE_W) ? K_W : cfar2d_pkg::SCALE_W;
  localparam int PR_W    = A_W + B_W;
  localparam int CMP_W   = SUM_W + B_W;

  // (a - b) mod RING for a, b below RING
  function automatic logic [RING_W-1:0] ring_back(input logic [RING_W-1:0] a,
                                                  input logic [RING_W-1:0] b);
    logic [RING_W:0] s;
    s = {1'b0, a} + (RING_W+1)'(RING) - {1'b0, b};
    if (s >= (RING_W+1)'(RING)) s = s - (RING_W+1)'(RING);
    return s[RING_W-1:0];
  endfunction

  function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] a);
    return (a == RING_W'(RING-1)) ? '0 : a + 1'b1;
  endfunction

  // Raster position of the next cell
  logic [ROW_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [RING_W-1:0] in_ring_r;

  // Newest cell and judged cell
  logic [ROW_W-1:0]       cur_row_r;
  logic [COL_W-1:0]       cur_col_r;
  logic [RING_W-1:0]      cur_ring_r;
  logic [P_W-1:0]         p_r;
  logic [P_W-1:0]         lag_r;
  logic signed [CR_W-1:0] cr_r;
  logic signed [CC_W-1:0] cc_r;
  logic [RING_W-1:0]      ring_r;

  // Window sweep
  logic [RING_W-1:0]     wr_ring_r;
  logic [COL_W-1:0]      col_base_r;
  logic [RING_W-1:0]     dr_r;
  logic [RING_W-1:0]     dc_r;
  logic                  rv_r;
  logic                  rtr_r;
  logic                  rcen_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CELLS_W-1:0]    cells_r;
  logic [POWER_BITS-1:0] centre_r;

  // Threshold compare
  logic [1:0]       mp_r;
  logic [1:0]       ptag_r;
  logic             pv_r;
  logic [PR_W-1:0]  prod_r;
  logic [CMP_W-1:0] lhs_r;
  logic [CMP_W-1:0] rhs_r;
  logic             det_r;

  // Output register
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_det_r;

  // Line store ports
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic [POWER_BITS-1:0] rdata;

  // Entry wrap, store address and advance of the raster position
  logic [RW2-1:0]    r1;
  logic [COL_W-1:0]  c1;
  logic [RING_W-1:0] g1;
  logic [RW2-1:0]    r3;
  logic [CW2-1:0]    c3;
  logic [RING_W-1:0] g3;

  always_comb begin
    r1 = in_sof ? '0 : RW2'(in_row_r);
    c1 = in_sof ? '0 : in_col_r;
    g1 = in_sof ? '0 : in_ring_r;
    if (CW2'(c1) >= CW2'(cols)) begin
      c1 = '0;
      r1 = r1 + 1'b1;
      g1 = ring_next(g1);
    end
    if (r1 >= RW2'(rows)) begin
      r1 = '0;
      g1 = '0;
    end
    r3 = r1;
    g3 = g1;
    c3 = CW2'(c1) + 1'b1;
    if (c3 >= CW2'(cols)) begin
      c3 = '0;
      r3 = r1 + 1'b1;
      g3 = ring_next(g1);
      if (r3 >= RW2'(rows)) begin
        r3 = '0;
        g3 = '0;
      end
    end
  end

  assign waddr = ADDR_W'(int'(g1) * MAX_COLUMNS + int'(c1));

  // Window geometry of the current sweep position
  logic [RING_W-1:0] two_o;
  logic [RING_W-1:0] g_lo;
  logic [RING_W-1:0] g_hi;
  logic              in_guard;
  logic              is_cen;

  assign two_o    = RING_W'({outer, 1'b0});
  assign g_lo     = RING_W'(outer) - RING_W'(guard);
  assign g_hi     = RING_W'(outer) + RING_W'(guard);
  assign in_guard = (dr_r >= g_lo) && (dr_r <= g_hi) && (dc_r >= g_lo) && (dc_r <= g_hi);
  assign is_cen   = (dr_r == RING_W'(outer)) && (dc_r == RING_W'(outer));
  assign raddr    = ADDR_W'(int'(wr_ring_r) * MAX_COLUMNS + int'(col_base_r) + int'(dc_r));

  cfar2d_ram #(
    .WIDTH (POWER_BITS),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.take),
    .waddr (waddr),
    .wdata (in_power),
    .re    (cmd.win_step),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Multiplier operand selection
  logic [A_W-1:0] mul_a;
  logic [B_W-1:0] mul_b;

  always_comb begin
    case (mp_r)
      cfar2d_pkg::PASS_CEN_LO: begin
        mul_a = A_W'(centre_r[CL-1:0]);
        mul_b = B_W'(cells_r) << cfar2d_pkg::SCALE_FRAC;
      end
      cfar2d_pkg::PASS_CEN_HI: begin
        mul_a = A_W'(centre_r[POWER_BITS-1:CL]);
        mul_b = B_W'(cells_r) << cfar2d_pkg::SCALE_FRAC;
      end
      cfar2d_pkg::PASS_SUM_LO: begin
        mul_a = A_W'(sum_r[SL-1:0]);
        mul_b = B_W'(scale);
      end
      default: begin
        mul_a = A_W'(sum_r[SUM_W-1:SL]);
        mul_b = B_W'(scale);
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_ring_r   <= '0;
      rv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= cmd.win_step;
      pv_r <= cmd.mul_step;
      if (cmd.take) begin
        in_row_r  <= r3[ROW_W-1:0];
        in_col_r  <= c3[COL_W-1:0];
        in_ring_r <= g3;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    // latch the newest cell
    if (cmd.take) begin
      cur_row_r  <= r1[ROW_W-1:0];
      cur_col_r  <= c1;
      cur_ring_r <= g1;
    end

    // raster index of the newest cell and the lag of the judged cell
    if (cmd.pos) begin
      p_r    <= P_W'(cur_row_r) * P_W'(cols) + P_W'(cur_col_r);
      lag_r  <= P_W'(outer) * P_W'(cols) + P_W'(outer);
      cr_r   <= $signed(CR_W'(cur_row_r)) - $signed(CR_W'(outer));
      cc_r   <= $signed(CC_W'(cur_col_r)) - $signed(CC_W'(outer));
      ring_r <= ring_back(cur_ring_r, RING_W'(outer));
    end else if (cmd.borrow) begin
      cc_r   <= cc_r + $signed(CC_W'(cols));
      cr_r   <= cr_r - CR_W'(1);
      ring_r <= ring_back(ring_r, RING_W'(1));
    end

    // window sweep: start, advance, accumulate the registered read data behind the read
    if (cmd.win_init) begin
      wr_ring_r  <= ring_back(ring_r, RING_W'(outer));
      col_base_r <= COL_W'(int'(cc_r) - int'(outer));
      dr_r       <= '0;
      dc_r       <= '0;
      sum_r      <= '0;
      cells_r    <= '0;
      mp_r       <= cfar2d_pkg::PASS_CEN_LO;
      lhs_r      <= '0;
      rhs_r      <= '0;
    end else begin
      if (cmd.win_step) begin
        rtr_r  <= !in_guard;
        rcen_r <= is_cen;
        if (dc_r == two_o) begin
          dc_r      <= '0;
          dr_r      <= dr_r + 1'b1;
          wr_ring_r <= ring_next(wr_ring_r);
        end else begin
          dc_r <= dc_r + 1'b1;
        end
      end
      if (rv_r) begin
        if (rtr_r) begin
          sum_r   <= sum_r + SUM_W'(rdata);
          cells_r <= cells_r + 1'b1;
        end
        if (rcen_r) begin
          centre_r <= rdata;
        end
      end
      if (cmd.mul_step) begin
        prod_r <= PR_W'(mul_a) * PR_W'(mul_b);
        ptag_r <= mp_r;
        mp_r   <= mp_r + 1'b1;
      end
      if (pv_r) begin
        case (ptag_r)
          cfar2d_pkg::PASS_CEN_LO: lhs_r <= lhs_r + CMP_W'(prod_r);
          cfar2d_pkg::PASS_CEN_HI: lhs_r <= lhs_r + (CMP_W'(prod_r) << CL);
          cfar2d_pkg::PASS_SUM_LO: rhs_r <= rhs_r + CMP_W'(prod_r);
          default:                 rhs_r <= rhs_r + (CMP_W'(prod_r) << SL);
        endcase
      end
    end

    // verdict: cleared for border cells, set by the compare otherwise
    if (cmd.win_init) begin
      det_r <= 1'b0;
    end else if (cmd.cmp) begin
      det_r <= (lhs_r > rhs_r);
    end

    if (cmd.out_load) begin
      out_row_r <= ROW_W'(cr_r);
      out_col_r <= COL_W'(cc_r);
      out_det_r <= det_r;
    end
  end

  // Status back to the controller
  assign status.early    = (p_r < lag_r);
  assign status.cc_neg   = cc_r[CC_W-1];
  assign status.interior = (int'(cr_r) >= int'(outer)) &&
                           (int'(cr_r) + int'(outer) < int'(rows)) &&
                           (int'(cc_r) >= int'(outer)) &&
                           (int'(cc_r) + int'(outer) < int'(cols));
  assign status.win_last = (dr_r == two_o) && (dc_r == two_o);
  assign status.mul_last = (mp_r == cfar2d_pkg::PASS_SUM_HI);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_det   = out_det_r;

endmodule

`default_nettype wire

// File: rtl/cfar_2d_detector_core.sv
// ---------------------------------------------------------------------------
// cfar_2d_detector_core
// Two-dimensional cell-averaging CFAR detector over a raster power map.
// ---------------------------------------------------------------------------
// Each beat on in_stream carries one power cell in raster order; the block
// answers with the verdict for the cell outer*columns+outer positions back,
// where outer = training + guard radius, and gives no beat while the map is
// too young for that. Border cells report detected = 0. One cell is handled
// at a time: in_stream is ready only between cells. Each cell is first
// located; a cell with no verdict yet is dropped there. Otherwise the
// judged cell is stepped back a row when its column lies within outer of
// the row start, and is tested against the border. For a cell with a full
// window the sweep reads the line store once per window cell through its
// single read port; the block then drains the read, runs the four-pass
// compare and loads the output. A border cell goes straight to the output.
// A verdict that finds the output register still waiting on out_ready
// holds the block until that beat leaves. The line store holds
// 2*MAX_OUTER+1 rows and needs no clearing after reset. A finished verdict
// waits in the output register while the next cell is taken in.
// ---------------------------------------------------------------------------
`default_nettype none

module cfar_2d_detector_core #(
  parameter int MAX_COLUMNS = cfar2d_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cfar2d_pkg::MAX_ROWS_DEF,
  parameter int MAX_OUTER   = cfar2d_pkg::MAX_OUTER_DEF,
  parameter int POWER_BITS  = cfar2d_pkg::POWER_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  cfar2d_in_if.sink                              in_stream,
  cfar2d_out_if.source                           out_stream,
  input  wire logic                              cfg_we,
  input  wire logic [cfar2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfar2d_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int COLS_W = $clog2(MAX_COLUMNS+1);
  localparam int ROWS_W = $clog2(MAX_ROWS+1);
  localparam int OW     = $clog2(MAX_OUTER+1);

  logic [COLS_W-1:0]               cols;
  logic [ROWS_W-1:0]               rows;
  logic [OW-1:0]                   outer;
  logic [OW-1:0]                   guard;
  logic [cfar2d_pkg::SCALE_W-1:0]  scale;
  cfar2d_pkg::ctrl_cmd_t           ctrl_cmd;
  cfar2d_pkg::dp_status_t          dp_status;

  cfar2d_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_OUTER   (MAX_OUTER)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cols      (cols),
    .rows      (rows),
    .outer     (outer),
    .guard     (guard),
    .scale     (scale)
  );

  cfar2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_stream.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  cfar2d_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_OUTER   (MAX_OUTER),
    .POWER_BITS  (POWER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctrl_cmd),
    .status    (dp_status),
    .cols      (cols),
    .rows      (rows),
    .outer     (outer),
    .guard     (guard),
    .scale     (scale),
    .in_sof    (in_stream.start_of_frame),
    .in_power  (in_stream.power_value),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_row   (out_stream.cell_row),
    .out_col   (out_stream.cell_column),
    .out_det   (out_stream.detected)
  );

  // Checks on controller and datapath cooperation
`include "cfar_2d_detector_core_macros.svh"

  `CFAR2D_ASSERT_IMP(a_load_free, ctrl_cmd.out_load, dp_status.out_free, "load over busy beat")
  `CFAR2D_ASSERT_IMP(a_sweep_busy, ctrl_cmd.win_step, !in_stream.ready, "input open in sweep")
  `CFAR2D_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(ctrl_cmd), "more than one datapath command")
  `CFAR2D_ASSERT_NXT(a_take_pos, ctrl_cmd.take, ctrl_cmd.pos, "taken beat not located")

endmodule

`default_nettype wire
